### design/hrcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrcd_pkg
// Shared types and constants of the chunked response decoder.
// ----------------------------------------------------------------------------
package hrcd_pkg;

	localparam logic [1:0] KIND_BODY = 2'd0;
	localparam logic [1:0] KIND_LOC  = 2'd1;
	localparam logic [1:0] KIND_END  = 2'd2;

	localparam logic [1:0] ST_BODY     = 2'd0;
	localparam logic [1:0] ST_REDIRECT = 2'd1;
	localparam logic [1:0] ST_HEADERS  = 2'd2;

	localparam int TE_LEN   = 19;
	localparam int LOC_LEN  = 10;
	localparam int WORD_LEN = 7;

	// One result item.
	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] out_kind;
		logic [1:0] end_status;
		logic       run_last;
	} res_t;

	// Work handed from the front part to the back part: up to two results.
	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} job_t;

	function automatic logic [7:0] te_char(input logic [4:0] i);
		case (i)
			5'd0: te_char = "T";   5'd1: te_char = "r";   5'd2: te_char = "a";
			5'd3: te_char = "n";   5'd4: te_char = "s";   5'd5: te_char = "f";
			5'd6: te_char = "e";   5'd7: te_char = "r";   5'd8: te_char = "-";
			5'd9: te_char = "E";   5'd10: te_char = "n";  5'd11: te_char = "c";
			5'd12: te_char = "o";  5'd13: te_char = "d";  5'd14: te_char = "i";
			5'd15: te_char = "n";  5'd16: te_char = "g";  5'd17: te_char = ":";
			5'd18: te_char = " ";
			default: te_char = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] loc_char(input logic [3:0] i);
		case (i)
			4'd0: loc_char = "L"; 4'd1: loc_char = "o"; 4'd2: loc_char = "c";
			4'd3: loc_char = "a"; 4'd4: loc_char = "t"; 4'd5: loc_char = "i";
			4'd6: loc_char = "o"; 4'd7: loc_char = "n"; 4'd8: loc_char = ":";
			4'd9: loc_char = " ";
			default: loc_char = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] word_char(input logic [2:0] i);
		case (i)
			3'd0: word_char = "c"; 3'd1: word_char = "h"; 3'd2: word_char = "u";
			3'd3: word_char = "n"; 3'd4: word_char = "k"; 3'd5: word_char = "e";
			3'd6: word_char = "d";
			default: word_char = 8'h00;
		endcase
	endfunction

	// Hex digit value; bit 4 set means not a digit.
	function automatic logic [4:0] hex_val(input logic [7:0] b);
		if (b >= "0" && b <= "9") hex_val = {1'b0, b[3:0]};
		else if ((b >= "A" && b <= "F") || (b >= "a" && b <= "f"))
			hex_val = {1'b0, b[3:0] + 4'd9};
		else hex_val = 5'h10;
	endfunction

endpackage

### design/hrcd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrcd_front
// Parses the byte stream and produces jobs of up to two result items.
// ----------------------------------------------------------------------------
module hrcd_front #(
	parameter int LINE_LIMIT = 4095,
	parameter int SIZE_BITS  = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      in_byte,
	input  logic            stream_end,
	output logic            job_valid,
	input  logic            job_ready,
	output hrcd_pkg::job_t  job
);
	import hrcd_pkg::*;

	localparam int PW = $clog2(LINE_LIMIT + 1);

	typedef enum logic [2:0] {PH_HEADER, PH_RAW, PH_SIZE, PH_SKIP, PH_DATA, PH_DONE}
		phase_t;

	phase_t               phase_q;
	logic [PW-1:0]        pos_q;
	logic [2:0]           flags_q;
	logic [2:0]           wcnt_q;
	logic                 chunked_q;
	logic [7:0]           held_q [2];
	logic [SIZE_BITS-1:0] rem_q;
	logic [1:0]           skip_q;

	phase_t               phase_d;
	logic [PW-1:0]        pos_d;
	logic [2:0]           flags_d;
	logic [2:0]           wcnt_d;
	logic                 chunked_d;
	logic [SIZE_BITS-1:0] rem_d;
	logic [1:0]           skip_d;
	logic                 held_we;
	logic                 held_idx;
	job_t                 job_d;
	logic                 fire;
	logic [4:0]           hv;
	logic [PW-1:0]        li;
	logic [1:0]           sk;

	assign in_ready = !job_valid || job_ready;
	assign fire     = in_valid && in_ready;

	function automatic res_t mk(input logic [7:0] b, input logic [1:0] k,
		input logic [1:0] s, input logic l);
		res_t r;
		r.out_byte = b; r.out_kind = k; r.end_status = s; r.run_last = l;
		return r;
	endfunction

	always_comb begin
		phase_d = phase_q; pos_d = pos_q; flags_d = flags_q; wcnt_d = wcnt_q;
		chunked_d = chunked_q; rem_d = rem_q; skip_d = skip_q;
		held_we = 1'b0; held_idx = 1'b0;
		job_d = '0;
		hv = hex_val(in_byte);
		li = pos_q - PW'(LOC_LEN);
		sk = skip_q;
		if (stream_end) begin
			if (phase_q == PH_HEADER) begin
				job_d.cnt = 2'd1;
				job_d.r0 = mk(8'h00, KIND_END,
					(flags_q[2] && pos_q >= PW'(LOC_LEN)) ? ST_REDIRECT : ST_HEADERS, 1'b1);
			end else if (phase_q != PH_DONE) begin
				job_d.cnt = 2'd1;
				job_d.r0 = mk(8'h00, KIND_END, ST_BODY, 1'b1);
			end
			phase_d = PH_HEADER; pos_d = '0; flags_d = 3'b111; wcnt_d = '0;
			chunked_d = 1'b0; rem_d = '0; skip_d = '0;
		end else begin
			unique case (phase_q)
				PH_HEADER: begin
					if (pos_q < PW'(LINE_LIMIT)) begin
						if (pos_q >= PW'(2) || in_byte != ((pos_q == '0) ? 8'h0d : 8'h0a))
							flags_d[0] = 1'b0;
						if (pos_q < PW'(TE_LEN) && in_byte != te_char(pos_q[4:0]))
							flags_d[1] = 1'b0;
						if (pos_q < PW'(LOC_LEN) && in_byte != loc_char(pos_q[3:0]))
							flags_d[2] = 1'b0;
						if (flags_d[1] && pos_q >= PW'(TE_LEN)) begin
							if (in_byte == word_char(wcnt_q)) wcnt_d = wcnt_q + 3'd1;
							else wcnt_d = (in_byte == "c") ? 3'd1 : 3'd0;
							if (wcnt_d >= 3'(WORD_LEN)) begin
								chunked_d = 1'b1;
								wcnt_d = '0;
							end
						end
						if (flags_d[2] && pos_q >= PW'(LOC_LEN)) begin
							held_we = 1'b1;
							held_idx = li[0];
							if (li >= PW'(2)) begin
								job_d.cnt = 2'd1;
								job_d.r0 = mk(held_q[li[0]], KIND_LOC, ST_BODY, 1'b0);
							end
						end
						pos_d = pos_q + PW'(1);
					end
					if (in_byte == 8'h0a) begin
						if (flags_d[0] && pos_d == PW'(2)) begin
							phase_d = chunked_d ? PH_SIZE : PH_RAW;
							rem_d = '0;
						end else if (flags_d[2] && pos_d >= PW'(LOC_LEN)) begin
							if (job_d.cnt == 2'd1) begin
								job_d.cnt = 2'd2;
								job_d.r1 = mk(8'h00, KIND_END, ST_REDIRECT, 1'b1);
							end else begin
								job_d.cnt = 2'd1;
								job_d.r0 = mk(8'h00, KIND_END, ST_REDIRECT, 1'b1);
							end
							phase_d = PH_DONE;
						end
						pos_d = '0; flags_d = 3'b111; wcnt_d = '0;
					end
				end
				PH_RAW: begin
					job_d.cnt = 2'd1;
					job_d.r0 = mk(in_byte, KIND_BODY, ST_BODY, 1'b0);
				end
				PH_SIZE: begin
					if (!hv[4]) rem_d = {rem_q[SIZE_BITS-5:0], hv[3:0]};
					else if (rem_q == '0) begin
						job_d.cnt = 2'd1;
						job_d.r0 = mk(8'h00, KIND_END, ST_BODY, 1'b1);
						phase_d = PH_DONE;
					end else begin
						skip_d = 2'd1;
						phase_d = PH_SKIP;
					end
				end
				PH_SKIP: begin
					if (sk != 2'd0) sk = sk - 2'd1;
					skip_d = sk;
					if (sk == 2'd0) phase_d = (rem_q != '0) ? PH_DATA : PH_SIZE;
				end
				PH_DATA: begin
					job_d.cnt = 2'd1;
					job_d.r0 = mk(in_byte, KIND_BODY, ST_BODY, 1'b0);
					rem_d = rem_q - SIZE_BITS'(1);
					if (rem_d == '0) begin
						skip_d = 2'd2;
						phase_d = PH_SKIP;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER; pos_q <= '0; flags_q <= 3'b111; wcnt_q <= '0;
			chunked_q <= 1'b0; rem_q <= '0; skip_q <= '0; job_valid <= 1'b0;
		end else begin
			if (job_ready) job_valid <= 1'b0;
			if (fire) begin
				phase_q <= phase_d; pos_q <= pos_d; flags_q <= flags_d;
				wcnt_q <= wcnt_d; chunked_q <= chunked_d; rem_q <= rem_d;
				skip_q <= skip_d;
				job_valid <= (job_d.cnt != 2'd0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			job <= job_d;
			if (held_we && !stream_end) held_q[held_idx] <= in_byte;
		end
	end

endmodule

### design/hrcd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrcd_back
// Two-entry job queue and output stage that serializes the results.
// ----------------------------------------------------------------------------
module hrcd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	output logic            job_ready,
	input  hrcd_pkg::job_t  job,
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	output hrcd_pkg::res_t  res
);
	import hrcd_pkg::*;

	job_t       q_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       sub_q;
	logic       push, pop;

	assign job_ready     = (cnt_q != 2'd2);
	assign push          = job_valid && job_ready;
	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign res           = sub_q ? q_q[rd_q].r1 : q_q[rd_q].r0;
	// An item leaves the queue once its last result is taken.
	assign pop = m_axis_tvalid && m_axis_tready && (sub_q || q_q[rd_q].cnt == 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= '0; sub_q <= 1'b0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) begin
				rd_q <= !rd_q;
				sub_q <= 1'b0;
			end else if (m_axis_tvalid && m_axis_tready) begin
				sub_q <= 1'b1;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_q[wr_q] <= job;
	end

endmodule

### design/http_response_chunked_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_response_chunked_decoder_top
// HTTP/1.1 response decoder with chunked transfer coding.
// ----------------------------------------------------------------------------
// Takes response bytes, one per cycle while the output keeps up, and emits
// body bytes, location bytes of a redirect, and one end marker per response.
// A byte is parsed in the cycle it is accepted; the parser registers up to two
// results as one job, which then enters a two-entry queue. A byte that makes
// two results has them sent by the output side one after the other.
module http_response_chunked_decoder_top #(
	parameter int LINE_LIMIT = 4095,
	parameter int SIZE_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // in_byte
	input  logic        s_axis_tuser,  // stream_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // out_byte
	output logic [3:0]  m_axis_tuser,  // out_kind[1:0], end_status[3:2]
	output logic        m_axis_tlast   // run_last
);
	import hrcd_pkg::*;

	logic jv, jr;
	job_t jb;
	res_t rs;

	hrcd_front #(.LINE_LIMIT(LINE_LIMIT), .SIZE_BITS(SIZE_BITS)) u_front (
		.clk, .arst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_byte(s_axis_tdata), .stream_end(s_axis_tuser),
		.job_valid(jv), .job_ready(jr), .job(jb));

	hrcd_back u_back (
		.clk, .arst_n, .job_valid(jv), .job_ready(jr), .job(jb),
		.m_axis_tvalid, .m_axis_tready, .res(rs));

	assign m_axis_tdata = rs.out_byte;
	assign m_axis_tuser = {rs.end_status, rs.out_kind};
	assign m_axis_tlast = rs.run_last;

endmodule
